@@ rtl/color_blob_centroid_defines.svh @@
// assertion macros for the blob centroid block
`ifndef COLOR_BLOB_CENTROID_DEFINES_SVH
`define COLOR_BLOB_CENTROID_DEFINES_SVH

`ifndef SYNTHESIS

// overlapping implication, checked at every rising edge outside reset
`define CBC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cbc check failed");

// non-overlapping implication, consequent in the next cycle
`define CBC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cbc check failed");

`else

`define CBC_ASSERT_IMP(lbl, ante, cons)
`define CBC_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

@@ rtl/cbc_pkg.sv @@
package cbc_pkg;

  // frame geometry
  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 2048;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);

  // accumulator and result widths
  localparam int CNT_W   = 23;
  localparam int SUM_W   = 34;
  localparam int COORD_W = 11;
  localparam int LUMA_W  = 16;
  localparam int LIM_W   = 30;  // 100 * count
  localparam int SQ_W    = 2 * COORD_W;
  localparam int PROD_W  = 31;  // 314 * r * r
  localparam int STEP_W  = 4;

  // fixed-point constants, luminance in hundredths
  localparam int K_BLUE   = 11;
  localparam int K_GREEN  = 59;
  localparam int K_RED    = 30;
  localparam int K_RED200 = 200;
  localparam int K_HUNDRED = 100;
  localparam int K_PI100  = 314;
  localparam logic [7:0] MIN_LUMA_RESET = 8'd50;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic       line_end;
    logic       frame_end;
  } pixel_t;

  typedef struct packed {
    logic [COORD_W-1:0] center_x;
    logic [COORD_W-1:0] center_y;
    logic [COORD_W-1:0] radius;
    logic [CNT_W-1:0]   pixel_count;
    logic               found;
  } result_t;

  // sequencer states
  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_START    = 8'b0000_0010,
    S_DIVX     = 8'b0000_0100,
    S_DIVY     = 8'b0000_1000,
    S_SQ_MUL   = 8'b0001_0000,
    S_SQ_SCALE = 8'b0010_0000,
    S_SQ_CMP   = 8'b0100_0000,
    S_OUT      = 8'b1000_0000
  } state_t;

endpackage

@@ rtl/color_blob_centroid.sv @@
// ordinary pixel: a new pixel every cycle while idle
// frame-end pixel: when pixels matched, the shared 35-bit subtract/compare
//   unit does each centroid division bit by bit, then tests the radius bit
//   by bit over 11 bits before the result; no pixel is taken meanwhile
// synchronous active-high reset: min_luma back to 50, position, count and
//   sums cleared, no result pending
module color_blob_centroid (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  cbc_pkg::pixel_t  in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output cbc_pkg::result_t out_data,
  input  logic             cfg_we,
  input  logic [7:0]       cfg_data
);

`include "color_blob_centroid_defines.svh"

  cbc_pkg::state_t state;

  logic [7:0]                   min_luma;
  logic [cbc_pkg::COL_W-1:0]    col_pos;
  logic [cbc_pkg::ROW_W-1:0]    row_pos;
  logic [cbc_pkg::CNT_W-1:0]    match_count;
  logic [cbc_pkg::SUM_W-1:0]    sum_cols;
  logic [cbc_pkg::SUM_W-1:0]    sum_rows;

  // datapath registers of the sequencer
  logic [cbc_pkg::SUM_W-1:0]    rem;
  logic [cbc_pkg::SUM_W-1:0]    dvs;
  logic [cbc_pkg::COORD_W-1:0]  quo;
  logic [cbc_pkg::STEP_W-1:0]   step;
  logic [cbc_pkg::COORD_W-1:0]  cx;
  logic [cbc_pkg::COORD_W-1:0]  cy;
  logic [cbc_pkg::COORD_W-1:0]  rad;
  logic [cbc_pkg::COORD_W-1:0]  mask;
  logic [cbc_pkg::SQ_W-1:0]     sq;
  logic [cbc_pkg::PROD_W-1:0]   prod;
  logic [cbc_pkg::LIM_W-1:0]    lim;

  logic                         in_acc;
  logic                         out_load;
  logic                         match;
  logic [cbc_pkg::LUMA_W-1:0]   luma;
  logic [cbc_pkg::LUMA_W-1:0]   red200;
  logic [cbc_pkg::LUMA_W-1:0]   luma_floor;
  logic [9:0]                   red2;
  logic [9:0]                   blue3;
  logic [9:0]                   green3;

  logic [cbc_pkg::CNT_W-1:0]    count_next;
  logic [cbc_pkg::SUM_W:0]      sum_cols_raw;
  logic [cbc_pkg::SUM_W:0]      sum_rows_raw;
  logic [cbc_pkg::SUM_W-1:0]    sum_cols_next;
  logic [cbc_pkg::SUM_W-1:0]    sum_rows_next;

  logic [cbc_pkg::SUM_W-1:0]    opa;
  logic [cbc_pkg::SUM_W-1:0]    opb;
  logic [cbc_pkg::SUM_W:0]      diff;
  logic                         ge;
  logic [cbc_pkg::COORD_W-1:0]  quo_final;
  logic                         div_done;
  logic [cbc_pkg::COORD_W-1:0]  trial;

  assign in_ready = (state == cbc_pkg::S_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign out_load = (state == cbc_pkg::S_OUT) && (!out_valid || out_ready);

  // color test in hundredths of luminance
  assign luma = cbc_pkg::LUMA_W'(in_data.blue)  * cbc_pkg::LUMA_W'(cbc_pkg::K_BLUE)
              + cbc_pkg::LUMA_W'(in_data.green) * cbc_pkg::LUMA_W'(cbc_pkg::K_GREEN)
              + cbc_pkg::LUMA_W'(in_data.red)   * cbc_pkg::LUMA_W'(cbc_pkg::K_RED);
  assign red200     = cbc_pkg::LUMA_W'(in_data.red) * cbc_pkg::LUMA_W'(cbc_pkg::K_RED200);
  assign luma_floor = cbc_pkg::LUMA_W'(min_luma) * cbc_pkg::LUMA_W'(cbc_pkg::K_HUNDRED);
  assign red2   = {1'b0, in_data.red, 1'b0};
  assign blue3  = 10'(in_data.blue)  * 10'd3;
  assign green3 = 10'(in_data.green) * 10'd3;
  assign match  = (red200 > luma) && (red2 > blue3) && (red2 > green3) &&
                  (luma > luma_floor);

  // saturating accumulators
  assign count_next   = (match_count == '1) ? match_count : match_count + 1'b1;
  assign sum_cols_raw = {1'b0, sum_cols} + (cbc_pkg::SUM_W + 1)'(col_pos);
  assign sum_rows_raw = {1'b0, sum_rows} + (cbc_pkg::SUM_W + 1)'(row_pos);
  assign sum_cols_next = sum_cols_raw[cbc_pkg::SUM_W] ? '1 : sum_cols_raw[cbc_pkg::SUM_W-1:0];
  assign sum_rows_next = sum_rows_raw[cbc_pkg::SUM_W] ? '1 : sum_rows_raw[cbc_pkg::SUM_W-1:0];

  // shared subtract/compare unit: division steps or radius test
  assign opa  = (state == cbc_pkg::S_SQ_CMP) ? cbc_pkg::SUM_W'(lim)  : rem;
  assign opb  = (state == cbc_pkg::S_SQ_CMP) ? cbc_pkg::SUM_W'(prod) : dvs;
  assign diff = {1'b0, opa} - {1'b0, opb};
  assign ge   = !diff[cbc_pkg::SUM_W];

  // quotient after this step; top step only checks for clamping
  assign quo_final = (step == cbc_pkg::STEP_W'(cbc_pkg::COORD_W)) ?
                     '1 : {quo[cbc_pkg::COORD_W-2:0], ge};
  assign div_done  = ((step == cbc_pkg::STEP_W'(cbc_pkg::COORD_W)) && ge) || (step == '0);
  assign trial     = rad | mask;

  // control state, configuration and frame accumulators
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= cbc_pkg::S_IDLE;
      out_valid   <= 1'b0;
      min_luma    <= cbc_pkg::MIN_LUMA_RESET;
      col_pos     <= '0;
      row_pos     <= '0;
      match_count <= '0;
      sum_cols    <= '0;
      sum_rows    <= '0;
    end else begin
      if (cfg_we) begin
        min_luma <= cfg_data;
      end
      if (out_valid && out_ready && !out_load) begin
        out_valid <= 1'b0;
      end

      // pixel accumulation and position tracking
      if (in_acc) begin
        if (match) begin
          match_count <= count_next;
          sum_cols    <= sum_cols_next;
          sum_rows    <= sum_rows_next;
        end
        if (in_data.frame_end) begin
          state <= cbc_pkg::S_START;
        end else if (in_data.line_end) begin
          col_pos <= '0;
          if (row_pos != '1) begin
            row_pos <= row_pos + 1'b1;
          end
        end else if (col_pos != '1) begin
          col_pos <= col_pos + 1'b1;
        end
      end

      // sequencer
      unique case (state)
        cbc_pkg::S_IDLE: begin
        end
        cbc_pkg::S_START: begin
          state <= (match_count == '0) ? cbc_pkg::S_OUT : cbc_pkg::S_DIVX;
        end
        cbc_pkg::S_DIVX: begin
          if (div_done) begin
            state <= cbc_pkg::S_DIVY;
          end
        end
        cbc_pkg::S_DIVY: begin
          if (div_done) begin
            state <= cbc_pkg::S_SQ_MUL;
          end
        end
        cbc_pkg::S_SQ_MUL: begin
          state <= cbc_pkg::S_SQ_SCALE;
        end
        cbc_pkg::S_SQ_SCALE: begin
          state <= cbc_pkg::S_SQ_CMP;
        end
        cbc_pkg::S_SQ_CMP: begin
          state <= mask[0] ? cbc_pkg::S_OUT : cbc_pkg::S_SQ_MUL;
        end
        cbc_pkg::S_OUT: begin
          if (out_load) begin
            out_valid   <= 1'b1;
            state       <= cbc_pkg::S_IDLE;
            col_pos     <= '0;
            row_pos     <= '0;
            match_count <= '0;
            sum_cols    <= '0;
            sum_rows    <= '0;
          end
        end
        default: begin
          state <= cbc_pkg::S_IDLE;
        end
      endcase
    end
  end

  // datapath of the divider and the radius search
  always_ff @(posedge clk) begin
    case (state)
      cbc_pkg::S_START: begin
        rem  <= sum_cols;
        dvs  <= cbc_pkg::SUM_W'(match_count) << cbc_pkg::COORD_W;
        step <= cbc_pkg::STEP_W'(cbc_pkg::COORD_W);
        quo  <= '0;
        lim  <= cbc_pkg::LIM_W'(match_count) * cbc_pkg::LIM_W'(cbc_pkg::K_HUNDRED);
        cx   <= '0;
        cy   <= '0;
        rad  <= '0;
      end
      cbc_pkg::S_DIVX, cbc_pkg::S_DIVY: begin
        if (div_done) begin
          if (state == cbc_pkg::S_DIVX) begin
            cx <= quo_final;
          end else begin
            cy <= quo_final;
          end
          // set up the next division or the radius search
          rem  <= sum_rows;
          dvs  <= cbc_pkg::SUM_W'(match_count) << cbc_pkg::COORD_W;
          step <= cbc_pkg::STEP_W'(cbc_pkg::COORD_W);
          quo  <= '0;
          mask <= {1'b1, {(cbc_pkg::COORD_W-1){1'b0}}};
        end else begin
          if (ge && (step != cbc_pkg::STEP_W'(cbc_pkg::COORD_W))) begin
            rem <= diff[cbc_pkg::SUM_W-1:0];
          end
          quo  <= (step == cbc_pkg::STEP_W'(cbc_pkg::COORD_W)) ? '0 : quo_final;
          dvs  <= dvs >> 1;
          step <= step - 1'b1;
        end
      end
      cbc_pkg::S_SQ_MUL: begin
        sq <= cbc_pkg::SQ_W'(trial) * cbc_pkg::SQ_W'(trial);
      end
      cbc_pkg::S_SQ_SCALE: begin
        prod <= cbc_pkg::PROD_W'(sq) * cbc_pkg::PROD_W'(cbc_pkg::K_PI100);
      end
      cbc_pkg::S_SQ_CMP: begin
        if (ge) begin
          rad <= trial;
        end
        mask <= mask >> 1;
      end
      cbc_pkg::S_OUT: begin
        if (out_load) begin
          out_data.center_x    <= cx;
          out_data.center_y    <= cy;
          out_data.radius      <= rad;
          out_data.pixel_count <= match_count;
          out_data.found       <= (match_count != '0);
        end
      end
      default: begin
      end
    endcase
  end

  // checks
  `CBC_ASSERT_IMP(a_found_count, out_valid, out_data.found == (out_data.pixel_count != '0))
  `CBC_ASSERT_IMP(a_empty_zero, out_valid && !out_data.found, (out_data.center_x == '0) && (out_data.center_y == '0) && (out_data.radius == '0))
  `CBC_ASSERT_NXT(a_frame_busy, in_acc && in_data.frame_end, !in_ready)
  `CBC_ASSERT_NXT(a_rad_grows, state == cbc_pkg::S_SQ_CMP, rad >= $past(rad))
  `CBC_ASSERT_IMP(a_mask_hot, (state == cbc_pkg::S_SQ_MUL) || (state == cbc_pkg::S_SQ_SCALE) || (state == cbc_pkg::S_SQ_CMP), $onehot(mask))

endmodule
